// File: hdl/ordered_list_store_macros.svh
// Assertion macros for the ordered list store controller.
`ifndef ORDERED_LIST_STORE_MACROS_SVH
`define ORDERED_LIST_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled in reset.
`define OLST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ordered list store: check failed");

// Next-cycle implication, disabled in reset.
`define OLST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ordered list store: check failed");

`else

`define OLST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OLST_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/olst_pkg.sv
package olst_pkg;

	localparam int OP_W         = 3;
	localparam int POS_W        = 7;
	localparam int DATA_W       = 32;
	localparam int ST_W         = 2;
	localparam int CNT_OUT_W    = 7;
	localparam int CAPACITY_DEF = 64;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_DROP   = 3'd2,
		OP_REMOVE = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Per-cell controls
	typedef struct packed {
		logic load_word;
		logic take_left;
		logic take_right;
		logic rd_load;
		logic rd_shift;
	} cell_ctl_t;

	// Sequencer to cell row
	typedef struct packed {
		logic ins;
		logic rem;
		logic rd_load;
		logic rd_shift;
	} seq_ctl_t;

endpackage

// File: hdl/olst_cell.sv
module olst_cell (
	input  logic                                    clk,
	input  olst_pkg::cell_ctl_t                     ctl,
	input  logic signed [olst_pkg::DATA_W-1:0]      value,
	input  logic signed [olst_pkg::DATA_W-1:0]      left_data,
	input  logic signed [olst_pkg::DATA_W-1:0]      right_data,
	input  logic signed [olst_pkg::DATA_W-1:0]      right_rd,
	output logic signed [olst_pkg::DATA_W-1:0]      data,
	output logic signed [olst_pkg::DATA_W-1:0]      rd
);
	import olst_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (ctl.load_word) begin
			data_q <= value;
		end else if (ctl.take_left) begin
			data_q <= left_data;
		end else if (ctl.take_right) begin
			data_q <= right_data;
		end

		// read line: snapshot the row, then move one place towards cell 0 a cycle
		if (ctl.rd_load) begin
			rd_q <= data_q;
		end else if (ctl.rd_shift) begin
			rd_q <= right_rd;
		end
	end

	assign data = data_q;
	assign rd   = rd_q;

endmodule

// File: hdl/olst_ctrl.sv
`include "ordered_list_store_macros.svh"

module olst_ctrl #(
	parameter int CAPACITY = olst_pkg::CAPACITY_DEF,
	parameter int CMP_W    = 7
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [olst_pkg::OP_W-1:0]             op,
	input  logic [olst_pkg::POS_W-1:0]            position,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [olst_pkg::ST_W-1:0]             status,
	output logic signed [olst_pkg::DATA_W-1:0]    read_value,
	output logic [olst_pkg::CNT_OUT_W-1:0]        count,
	input  logic signed [olst_pkg::DATA_W-1:0]    rd_head,
	output olst_pkg::seq_ctl_t                    seq,
	output logic [CMP_W-1:0]                      at
);
	import olst_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [POS_W-1:0]         rd_cnt_q;
	logic                     pend_valid_q;
	status_t                  pend_status_q;
	logic signed [DATA_W-1:0] pend_value_q;
	logic [CNT_OUT_W-1:0]     pend_count_q;
	logic                     out_valid_q;
	status_t                  out_status_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic [CNT_OUT_W-1:0]     out_count_q;

	op_t                      op_c;
	logic [CMP_W-1:0]         c_x;
	logic [CMP_W-1:0]         p_x;
	logic                     is_full;
	logic                     is_empty;
	logic                     accept;
	status_t                  dec_status;
	logic signed [DATA_W-1:0] dec_value;
	logic [CNT_W-1:0]         dec_count;
	logic                     dec_ins;
	logic                     dec_rem;
	logic                     dec_rd;
	logic [CMP_W-1:0]         dec_at;

	assign op_c     = op_t'(op);
	assign c_x      = CMP_W'(count_q);
	assign p_x      = CMP_W'(position);
	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign in_stall = (state_q != S_IDLE) || pend_valid_q;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		dec_status = ST_OK;
		dec_value  = '0;
		dec_count  = count_q;
		dec_ins    = 1'b0;
		dec_rem    = 1'b0;
		dec_rd     = 1'b0;
		dec_at     = p_x;
		unique case (op_c) inside
			OP_APPEND: begin
				if (is_full) begin
					dec_status = ST_FULL;
					dec_value  = '1;
				end else begin
					dec_ins   = 1'b1;
					dec_at    = c_x;
					dec_count = count_q + CNT_W'(1);
				end
			end
			OP_INSERT: begin
				if (p_x > c_x) begin
					dec_status = ST_RANGE;
					dec_value  = '1;
				end else if (is_full) begin
					dec_status = ST_FULL;
					dec_value  = '1;
				end else begin
					dec_ins   = 1'b1;
					dec_count = count_q + CNT_W'(1);
				end
			end
			OP_DROP: begin
				if (is_empty) begin
					dec_status = ST_EMPTY;
					dec_value  = '1;
				end else begin
					dec_count = count_q - CNT_W'(1);
				end
			end
			OP_REMOVE, OP_READ: begin
				if (is_empty) begin
					dec_status = ST_EMPTY;
					dec_value  = '1;
				end else if (p_x >= c_x) begin
					dec_status = ST_RANGE;
					dec_value  = '1;
				end else if (op_c == OP_READ) begin
					dec_rd = 1'b1;
				end else begin
					dec_rem   = 1'b1;
					dec_count = count_q - CNT_W'(1);
				end
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	assign seq.ins      = accept && dec_ins;
	assign seq.rem      = accept && dec_rem;
	assign seq.rd_load  = accept && dec_rd;
	assign seq.rd_shift = (state_q == S_READ) && (rd_cnt_q != '0);
	assign at           = dec_at;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			rd_cnt_q      <= '0;
			pend_valid_q  <= 1'b0;
			pend_status_q <= ST_OK;
			pend_value_q  <= '0;
			pend_count_q  <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= ST_OK;
			out_value_q   <= '0;
			out_count_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			// advance the pending item into the output register when it frees
			if (pend_valid_q && (!out_valid_q || !out_stall)) begin
				out_valid_q  <= 1'b1;
				out_status_q <= pend_status_q;
				out_value_q  <= pend_value_q;
				out_count_q  <= pend_count_q;
				pend_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= dec_count;
						if (dec_rd) begin
							rd_cnt_q <= position;
							state_q  <= S_READ;
						end else begin
							pend_valid_q  <= 1'b1;
							pend_status_q <= dec_status;
							pend_value_q  <= dec_value;
							pend_count_q  <= CNT_OUT_W'(dec_count);
						end
					end
				end
				S_READ: begin
					if (rd_cnt_q == '0) begin
						pend_valid_q  <= 1'b1;
						pend_status_q <= ST_OK;
						pend_value_q  <= rd_head;
						pend_count_q  <= CNT_OUT_W'(count_q);
						state_q       <= S_IDLE;
					end else begin
						rd_cnt_q <= rd_cnt_q - POS_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_value = out_value_q;
	assign count      = out_count_q;

	`OLST_ASSERT_IMP(a_count_cap, clk, arst_n, 1'b1, count_q <= CNT_W'(CAPACITY))
	`OLST_ASSERT_IMP(a_read_blocks, clk, arst_n, state_q == S_READ, in_stall)
	`OLST_ASSERT_NEXT(a_drop_count, clk, arst_n,
		accept && op_c == OP_DROP && !is_empty, count_q == $past(count_q) - CNT_W'(1))
	`OLST_ASSERT_NEXT(a_read_enter, clk, arst_n,
		accept && dec_rd, state_q == S_READ && !pend_valid_q)

endmodule

// File: hdl/ordered_list_store.sv
// Channel   Handshake             Fields
// in        in_valid / in_stall   op, position, value
// out       out_valid / out_stall status, read_value, count
//
// On insert or remove, the row of cells shifts every entry at or above the position at once.
// Read: the cell row's read line moves one place a cycle to cell 0.
// One item is in work at a time; a finished result waits in a pending slot, so the next
// item is taken while the output register is stalled, until that slot is full.
// arst_n clears the count and all handshake state; entry contents are not cleared.
module ordered_list_store #(
	parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [olst_pkg::OP_W-1:0]             op,
	input  logic [olst_pkg::POS_W-1:0]            position,
	input  logic signed [olst_pkg::DATA_W-1:0]    value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [olst_pkg::ST_W-1:0]             status,
	output logic signed [olst_pkg::DATA_W-1:0]    read_value,
	output logic [olst_pkg::CNT_OUT_W-1:0]        count
);
	import olst_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	seq_ctl_t                 seq;
	logic [CMP_W-1:0]         at;
	logic signed [DATA_W-1:0] cell_data [CAPACITY];
	logic signed [DATA_W-1:0] cell_rd   [CAPACITY];

	olst_ctrl #(
		.CAPACITY (CAPACITY),
		.CMP_W    (CMP_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.count      (count),
		.rd_head    (cell_rd[0]),
		.seq        (seq),
		.at         (at)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t                ctl;
		logic signed [DATA_W-1:0] left_data;
		logic signed [DATA_W-1:0] right_data;
		logic signed [DATA_W-1:0] right_rd;

		// insert: the target cell loads, cells above take from below
		// remove: the target cell and all above take from above
		assign ctl.load_word  = seq.ins && (at == CMP_W'(i));
		assign ctl.take_left  = seq.ins && (at < CMP_W'(i));
		assign ctl.take_right = seq.rem && !(CMP_W'(i) < at);
		assign ctl.rd_load    = seq.rd_load;
		assign ctl.rd_shift   = seq.rd_shift;

		if (i == 0) begin : g_first
			assign left_data = '0;
		end else begin : g_inner_l
			assign left_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_data = '0;
			assign right_rd   = '0;
		end else begin : g_inner_r
			assign right_data = cell_data[i+1];
			assign right_rd   = cell_rd[i+1];
		end

		olst_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.value      (value),
			.left_data  (left_data),
			.right_data (right_data),
			.right_rd   (right_rd),
			.data       (cell_data[i]),
			.rd         (cell_rd[i])
		);
	end

endmodule

// File: bench/ordered_list_store_tb.sv
`timescale 1ns / 100ps

module ordered_list_store_tb;
	import olst_pkg::*;

	localparam int CAPACITY = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 1600;
	localparam int QUIET_ITEMS = 200;
	localparam int HOLD_AFTER = 400;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT = 800000;
	localparam int NUM_ROWS = 25;

	localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
	localparam logic signed [DATA_W-1:0] ERR_WORD = -32'sd1;
	localparam logic [POS_W-1:0] POS_TOP = 7'd127;

	localparam int MODE_GROW = 0;
	localparam int MODE_SHRINK = 1;
	localparam int MODE_MIXED = 2;

	typedef struct packed {
		status_t                    st;
		logic signed [DATA_W-1:0]   word;
		logic [CNT_OUT_W-1:0]       cnt;
	} list_result_t;

	typedef struct packed {
		logic [OP_W-1:0]            code;
		logic [POS_W-1:0]           pos;
		logic signed [DATA_W-1:0]   word;
		logic                       typed;
		status_t                    st;
		logic signed [DATA_W-1:0]   rd;
		logic [CNT_OUT_W-1:0]       cnt;
	} request_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [OP_W-1:0] op = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [ST_W-1:0] status;
	logic signed [DATA_W-1:0] read_value;
	logic [CNT_OUT_W-1:0] count;

	// Typed expectation travels alongside the payload of each table row
	logic row_typed = 1'b0;
	status_t row_st = ST_OK;
	logic signed [DATA_W-1:0] row_rd = '0;
	logic [CNT_OUT_W-1:0] row_cnt = '0;

	logic signed [DATA_W-1:0] list_words [CAPACITY];
	int list_len = 0;
	list_result_t pending_results[$];
	int mismatches = 0;
	int items_in = 0;
	bit quiet = 1'b0;
	bit held_long = 1'b0;
	int unsigned cycle_count = 0;

	ordered_list_store dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.count      (count)
	);

	request_row_t dir_rows [NUM_ROWS] = '{
		'{OP_DROP,   7'd0,   32'sd0,           1'b1, ST_EMPTY, ERR_WORD,         7'd0},
		'{OP_REMOVE, 7'd0,   32'sd0,           1'b1, ST_EMPTY, ERR_WORD,         7'd0},
		'{OP_READ,   7'd0,   32'sd0,           1'b1, ST_EMPTY, ERR_WORD,         7'd0},
		'{OP_READ,   POS_TOP, 32'sd0,          1'b1, ST_EMPTY, ERR_WORD,         7'd0},
		'{OP_INSERT, 7'd1,   32'sd5,           1'b1, ST_RANGE, ERR_WORD,         7'd0},
		'{OP_INSERT, 7'd0,   32'sh7FFFFFFF,    1'b1, ST_OK,    32'sd0,           7'd1},
		'{OP_APPEND, 7'd0,   32'sh80000000,    1'b1, ST_OK,    32'sd0,           7'd2},
		'{OP_READ,   7'd0,   32'sd0,           1'b1, ST_OK,    32'sh7FFFFFFF,    7'd2},
		'{OP_READ,   7'd1,   32'sd0,           1'b1, ST_OK,    32'sh80000000,    7'd2},
		'{OP_READ,   7'd2,   32'sd0,           1'b1, ST_RANGE, ERR_WORD,         7'd2},
		'{OP_READ,   POS_TOP, 32'sd0,          1'b1, ST_RANGE, ERR_WORD,         7'd2},
		'{OP_INSERT, 7'd1,   ERR_WORD,         1'b0, ST_OK,    32'sd0,           7'd0},
		'{OP_INSERT, 7'd3,   32'sh12345678,    1'b0, ST_OK,    32'sd0,           7'd0},
		'{OP_INSERT, POS_TOP, 32'sd9,          1'b1, ST_RANGE, ERR_WORD,         7'd4},
		'{OP_REMOVE, 7'd4,   32'sd0,           1'b1, ST_RANGE, ERR_WORD,         7'd4},
		'{OP_REMOVE, 7'd0,   32'sd0,           1'b0, ST_OK,    32'sd0,           7'd0},
		'{OP_READ,   7'd0,   32'sd0,           1'b0, ST_OK,    32'sd0,           7'd0},
		'{OP_SPARE5, 7'd3,   32'sd55,          1'b1, ST_OK,    32'sd0,           7'd3},
		'{OP_SPARE6, 7'd0,   ERR_WORD,         1'b1, ST_OK,    32'sd0,           7'd3},
		'{OP_SPARE7, POS_TOP, 32'sh7FFFFFFF,   1'b1, ST_OK,    32'sd0,           7'd3},
		'{OP_REMOVE, 7'd2,   32'sd0,           1'b0, ST_OK,    32'sd0,           7'd0},
		'{OP_READ,   7'd1,   32'sd0,           1'b0, ST_OK,    32'sd0,           7'd0},
		'{OP_DROP,   7'd0,   32'sd0,           1'b0, ST_OK,    32'sd0,           7'd0},
		'{OP_DROP,   7'd0,   32'sd0,           1'b0, ST_OK,    32'sd0,           7'd0},
		'{OP_DROP,   7'd0,   32'sd0,           1'b1, ST_EMPTY, ERR_WORD,         7'd0}
	};

	function automatic list_result_t apply_request(logic [OP_W-1:0] code,
			logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] word);
		list_result_t res;
		int i;
		int at;
		at = int'(pos);
		res.st = ST_OK;
		res.word = '0;
		case (code)
		OP_APPEND: begin
			if (list_len >= CAPACITY) begin
				res.st = ST_FULL;
			end else begin
				list_words[list_len] = word;
				list_len++;
			end
		end
		OP_INSERT: begin
			if (at > list_len) begin
				res.st = ST_RANGE;
			end else if (list_len >= CAPACITY) begin
				res.st = ST_FULL;
			end else begin
				for (i = list_len; i > at; i--)
					list_words[i] = list_words[i-1];
				list_words[at] = word;
				list_len++;
			end
		end
		OP_DROP: begin
			if (list_len == 0)
				res.st = ST_EMPTY;
			else
				list_len--;
		end
		OP_REMOVE, OP_READ: begin
			if (list_len == 0) begin
				res.st = ST_EMPTY;
			end else if (at >= list_len) begin
				res.st = ST_RANGE;
			end else if (code == OP_READ) begin
				res.word = list_words[at];
			end else begin
				for (i = at + 1; i < list_len; i++)
					list_words[i-1] = list_words[i];
				list_len--;
			end
		end
		default: ;
		endcase
		if (res.st != ST_OK)
			res.word = ERR_WORD;
		res.cnt = list_len[CNT_OUT_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("%0t: %s differs: got %0h, want %0h", $time, what, got, want);
		mismatches++;
	endtask

	// Hold the payload until the block takes it
	task automatic send_request(input request_row_t row);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= row.code;
		position <= row.pos;
		value <= row.word;
		row_typed <= row.typed;
		row_st <= row.st;
		row_rd <= row.rd;
		row_cnt <= row.cnt;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin : predict_blk
		list_result_t res;
		if (arst_n && in_valid && !in_stall) begin
			res = apply_request(op, position, value);
			if (row_typed) begin
				res.st = row_st;
				res.word = row_rd;
				res.cnt = row_cnt;
			end
			pending_results = {pending_results, res};
			items_in++;
		end
	end

	always @(posedge clk) begin : check_blk
		list_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item, status", DATA_W'(status), '0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report_mismatch("status", DATA_W'(status), DATA_W'(want.st));
				if (read_value !== want.word)
					report_mismatch("read_value", read_value, want.word);
				if (count !== want.cnt)
					report_mismatch("count", DATA_W'(count), DATA_W'(want.cnt));
			end
		end
	end

	initial begin
		@(posedge clk);
		forever begin
			if (!quiet && !held_long && items_in >= HOLD_AFTER) begin
				// long hold-off: let the block fill up and stall its input
				held_long = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus_blk
		request_row_t row;
		int sent;
		int run_left;
		int mode;
		int pick;
		int hint;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < NUM_ROWS; r++)
			send_request(dir_rows[r]);

		sent = 0;
		run_left = 0;
		mode = MODE_MIXED;
		while (sent < RANDOM_ITEMS) begin
			if (run_left == 0) begin
				mode = $urandom_range(MODE_GROW, MODE_MIXED);
				run_left = $urandom_range(10, 90);
			end
			run_left--;
			quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
			pick = $urandom_range(0, 99);
			case (mode)
			MODE_GROW:
				row.code = (pick < 45) ? OP_APPEND : (pick < 90) ? OP_INSERT : OP_READ;
			MODE_SHRINK:
				row.code = (pick < 40) ? OP_DROP : (pick < 85) ? OP_REMOVE : OP_READ;
			default:
				row.code = (pick < 60) ? OP_READ : (pick < 70) ? OP_APPEND :
					(pick < 80) ? OP_INSERT : (pick < 90) ? OP_REMOVE : OP_DROP;
			endcase
			if ($urandom_range(0, 39) == 0)
				row.code = OP_W'($urandom_range(OP_SPARE5, OP_SPARE7));
			// the list length only steers positions towards legal ones
			hint = list_len;
			if ($urandom_range(0, 9) == 0)
				row.pos = POS_W'($urandom_range(0, POS_TOP));
			else if (row.code == OP_INSERT)
				row.pos = POS_W'($urandom_range(0, hint));
			else
				row.pos = (hint == 0) ? '0 : POS_W'($urandom_range(0, hint - 1));
			row.word = $urandom;
			row.typed = 1'b0;
			row.st = ST_OK;
			row.rd = '0;
			row.cnt = '0;
			send_request(row);
			if (row.code <= OP_READ)
				sent++;
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/olst_pkg.sv
hdl/olst_cell.sv
hdl/olst_ctrl.sv
hdl/ordered_list_store.sv
bench/ordered_list_store_tb.sv
